// ===== hw/rtl/running_avg_min_max_tracker_assert.svh =====
// Assertion macros used by the checker file of the statistics tracker.
`ifndef RUNNING_AVG_MIN_MAX_TRACKER_ASSERT_SVH
`define RUNNING_AVG_MIN_MAX_TRACKER_ASSERT_SVH

// Property checked at every rising clock edge while out of reset.
`define RAMM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Implication checked in the same cycle.
`define RAMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	`RAMM_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Implication whose consequent is checked in the next cycle.
`define RAMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	`RAMM_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/ramm_pkg.sv =====
// Shared constants and types of the running average and min/max tracker.
`default_nettype none

package ramm_pkg;

	localparam int CHANNELS_DEF   = 8;
	localparam int VALUE_BITS_DEF = 16;
	localparam int CHAN_BITS      = 3;
	localparam int COUNT_BITS     = 16;

	typedef enum logic [0:0] {
		OP_UPDATE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ramm_stats_mem.sv =====
// Per-channel statistics memory, one write port and one registered read port.
`default_nettype none

module ramm_stats_mem #(
	parameter int DEPTH = ramm_pkg::CHANNELS_DEF,
	parameter int AW    = 3,
	parameter int W     = 3 * ramm_pkg::VALUE_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [W-1:0]  rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [W-1:0]  wr_data
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ramm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the rounded average.
`default_nettype none

module ramm_div #(
	parameter int VALUE_BITS = ramm_pkg::VALUE_BITS_DEF
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         start,
	input  wire logic [VALUE_BITS+ramm_pkg::COUNT_BITS:0]     dividend,
	input  wire logic [ramm_pkg::COUNT_BITS:0]                divisor,
	output logic                                              done,
	output logic      [VALUE_BITS-1:0]                        quotient
);

	localparam int DW = VALUE_BITS + ramm_pkg::COUNT_BITS + 1;
	localparam int RW = ramm_pkg::COUNT_BITS + 1;
	localparam int CW = $clog2(VALUE_BITS + 1);

	logic [RW-1:0]         rem_q;
	logic [VALUE_BITS-1:0] qd_q;
	logic [RW-1:0]         dvs_q;
	logic [CW-1:0]         cnt_q;
	logic                  done_q;

	logic [RW:0]   rem_sh;
	logic          rem_ge;
	logic [RW:0]   rem_diff;
	logic [RW-1:0] rem_nx;

	// The quotient is known to fit VALUE_BITS, so the upper dividend bits
	// are already below the divisor and seed the remainder directly.
	always_comb begin
		rem_sh   = {rem_q, qd_q[VALUE_BITS-1]};
		rem_ge   = rem_sh >= {1'b0, dvs_q};
		rem_diff = rem_sh - {1'b0, dvs_q};
		rem_nx   = rem_ge ? rem_diff[RW-1:0] : rem_sh[RW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(VALUE_BITS);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - CW'(1);
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DW-1 -: RW];
			qd_q  <= dividend[VALUE_BITS-1:0];
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= rem_nx;
			qd_q  <= {qd_q[VALUE_BITS-2:0], rem_ge};
		end
	end

	assign done     = done_q;
	assign quotient = qd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/running_avg_min_max_tracker.sv =====
// Top level of the per-channel running average and min/max tracker.
//
//  channel   | handshake          | fields
//  ----------+--------------------+----------------------------------------------
//  request   | start / busy       | operation, channel, duration_tenths,
//            |                    | sample_count
//  result    | done (strobe)      | current_tenths, average_tenths,
//            |                    | minimum_tenths, maximum_tenths, stats_valid
//
// A request is taken at a rising edge with start high and busy low.
// Clear, out-of-range channel and update of an empty channel: the result
// strobe is registered in ST_READ, right after the edge that takes the request.
// Update of a filled channel: ST_READ, ST_LOAD, then ST_DIV with the one bit per
// cycle divider. A new request can be taken in the cycle the strobe is high.
// Reset empties every channel at once through per-channel valid flops.
// The result strobe is high for one cycle only; the receiver cannot stall it.
`default_nettype none

module running_avg_min_max_tracker #(
	parameter int CHANNELS   = ramm_pkg::CHANNELS_DEF,
	parameter int VALUE_BITS = ramm_pkg::VALUE_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                operation,
	input  wire logic [ramm_pkg::CHAN_BITS-1:0]      channel,
	input  wire logic [VALUE_BITS-1:0]               duration_tenths,
	input  wire logic [ramm_pkg::COUNT_BITS-1:0]     sample_count,
	output logic                                     done,
	output logic      [VALUE_BITS-1:0]               current_tenths,
	output logic      [VALUE_BITS-1:0]               average_tenths,
	output logic      [VALUE_BITS-1:0]               minimum_tenths,
	output logic      [VALUE_BITS-1:0]               maximum_tenths,
	output logic                                     stats_valid
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CB = ramm_pkg::COUNT_BITS;
	localparam int NW = VALUE_BITS + CB;
	localparam int DW = NW + 1;
	localparam int MW = 3 * VALUE_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIV
	} state_t;

	state_t state_q;
	logic [CHANNELS-1:0] filled_q;

	// Captured request.
	logic                  op_q;
	logic                  inrange_q;
	logic [AW-1:0]         idx_q;
	logic [VALUE_BITS-1:0] dur_q;
	logic [CB-1:0]         n_q;

	logic [NW-1:0]         num_q;
	logic [VALUE_BITS-1:0] min_q;
	logic [VALUE_BITS-1:0] max_q;

	logic                  accept;
	logic [MW-1:0]         rd_data;
	logic [VALUE_BITS-1:0] rd_avg;
	logic [VALUE_BITS-1:0] rd_min;
	logic [VALUE_BITS-1:0] rd_max;
	logic                  is_clear;
	logic                  is_filled;
	logic [NW-1:0]         num_nx;
	logic                  wr_en;
	logic [MW-1:0]         wr_data;

	logic                  div_start;
	logic [DW-1:0]         div_dividend;
	logic [CB:0]           div_divisor;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quot;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		rd_avg    = rd_data[MW-1 -: VALUE_BITS];
		rd_min    = rd_data[2*VALUE_BITS-1 -: VALUE_BITS];
		rd_max    = rd_data[VALUE_BITS-1:0];
		is_clear  = (op_q == ramm_pkg::OP_CLEAR);
		is_filled = filled_q[idx_q];
		num_nx    = NW'(rd_avg) * NW'(n_q - CB'(1)) + NW'(dur_q);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_data = {div_quot, min_q, max_q};
		if (state_q == ST_READ && inrange_q && !is_clear && !is_filled) begin
			wr_en   = 1'b1;
			wr_data = {dur_q, dur_q, dur_q};
		end else if (state_q == ST_DIV && div_done) begin
			wr_en = 1'b1;
		end
	end

	assign div_start    = (state_q == ST_LOAD);
	assign div_dividend = {num_q, 1'b0} + DW'(n_q);
	assign div_divisor  = {n_q, 1'b0};

	ramm_stats_mem #(
		.DEPTH (CHANNELS),
		.AW    (AW),
		.W     (MW)
	) u_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (AW'(channel)),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (idx_q),
		.wr_data (wr_data)
	);

	ramm_div #(
		.VALUE_BITS (VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= operation;
			inrange_q <= (32'(channel) < CHANNELS);
			idx_q     <= AW'(channel);
			dur_q     <= duration_tenths;
			n_q       <= (sample_count == '0) ? CB'(1) : sample_count;
		end
		if (state_q == ST_READ) begin
			num_q <= num_nx;
			min_q <= (dur_q < rd_min) ? dur_q : rd_min;
			max_q <= (dur_q > rd_max) ? dur_q : rd_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			filled_q       <= '0;
			done           <= 1'b0;
			current_tenths <= '0;
			average_tenths <= '0;
			minimum_tenths <= '0;
			maximum_tenths <= '0;
			stats_valid    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (!inrange_q || is_clear) begin
						if (inrange_q) begin
							filled_q[idx_q] <= 1'b0;
						end
						current_tenths <= '0;
						average_tenths <= '0;
						minimum_tenths <= '0;
						maximum_tenths <= '0;
						stats_valid    <= 1'b0;
						done           <= 1'b1;
						state_q        <= ST_IDLE;
					end else if (!is_filled) begin
						filled_q[idx_q] <= 1'b1;
						current_tenths  <= dur_q;
						average_tenths  <= dur_q;
						minimum_tenths  <= dur_q;
						maximum_tenths  <= dur_q;
						stats_valid     <= 1'b1;
						done            <= 1'b1;
						state_q         <= ST_IDLE;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						current_tenths <= dur_q;
						average_tenths <= div_quot;
						minimum_tenths <= min_q;
						maximum_tenths <= max_q;
						stats_valid    <= 1'b1;
						done           <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ramm_checker.sv =====
// Port-level checker of the statistics tracker and its bind to the top level.
`default_nettype none

`include "running_avg_min_max_tracker_assert.svh"

module ramm_checker #(
	parameter int VALUE_BITS = ramm_pkg::VALUE_BITS_DEF
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic                  done,
	input wire logic [VALUE_BITS-1:0] current_tenths,
	input wire logic [VALUE_BITS-1:0] average_tenths,
	input wire logic [VALUE_BITS-1:0] minimum_tenths,
	input wire logic [VALUE_BITS-1:0] maximum_tenths,
	input wire logic                  stats_valid
);

	// Every request needs a memory read first, so results never come back to back.
	`RAMM_ASSERT_NXT(a_no_double_done, clk, arst_n, done, !done, "two results in a row")

	`RAMM_ASSERT_NXT(a_busy_after_req, clk, arst_n, start && !busy, busy, "request not held")

	`RAMM_ASSERT_IMP(a_done_ends_busy, clk, arst_n, $fell(busy), done, "busy ended without result")

	`RAMM_ASSERT_IMP(a_empty_zero, clk, arst_n, done && !stats_valid, (current_tenths == '0) && (average_tenths == '0) && (minimum_tenths == '0) && (maximum_tenths == '0), "empty result not zero")

	// The average is a rounded weighted mean, so it stays between minimum and maximum.
	`RAMM_ASSERT_IMP(a_order, clk, arst_n, done && stats_valid, (minimum_tenths <= average_tenths) && (average_tenths <= maximum_tenths) && (minimum_tenths <= current_tenths) && (current_tenths <= maximum_tenths), "statistics out of order")

endmodule

bind running_avg_min_max_tracker ramm_checker #(
	.VALUE_BITS (VALUE_BITS)
) u_checker (.*);

`default_nettype wire
